FILE: rtl/moving_average_window_defines.svh
// Assertion macros shared by the moving average window RTL.
`ifndef MOVING_AVERAGE_WINDOW_DEFINES_SVH
`define MOVING_AVERAGE_WINDOW_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MAVW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("moving_average_window: assertion failed");

// Next-cycle implication, checked outside reset.
`define MAVW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("moving_average_window: assertion failed");

`endif

FILE: rtl/mavw_pkg.sv
// Types and fixed constants of the moving average window.
`default_nettype none

package mavw_pkg;

   localparam int WIN_BITS  = 7;
   localparam int AVG_BITS  = 24;
   localparam int FRAC_BITS = 8;

   localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd8;

   localparam logic signed [AVG_BITS-1:0] AVG_MAX = {1'b0, {(AVG_BITS-1){1'b1}}};
   localparam logic signed [AVG_BITS-1:0] AVG_MIN = {1'b1, {(AVG_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

FILE: rtl/mavw_ring.sv
// Sample ring memory: one write port, one registered read port.
`default_nettype none

module mavw_ring #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/mavw_sdiv.sv
// Bit-serial restoring divider: |sum| * 2^FRAC_BITS / count, signed result saturated.
`default_nettype none

module mavw_sdiv #(
   parameter int SUM_W = 22,
   parameter int CNT_W = 7
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [SUM_W-1:0]              start_sum,
   input  logic [CNT_W-1:0]                     start_count,
   output mavw_pkg::div_stat_type               stat,
   output logic signed [mavw_pkg::AVG_BITS-1:0] average
);

   import mavw_pkg::*;

   localparam int Q_W   = SUM_W + FRAC_BITS;
   localparam int CW    = $clog2(Q_W + 1);
   localparam int EXT_W = ((Q_W > AVG_BITS) ? Q_W : AVG_BITS) + 1;
   localparam logic [EXT_W-1:0] POS_LIM = EXT_W'(2**(AVG_BITS-1) - 1);
   localparam logic [EXT_W-1:0] NEG_LIM = EXT_W'(2**(AVG_BITS-1));

   logic [Q_W-1:0]   dq_ff, dq_in;      // dividend bits out at top, quotient bits in at bottom
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] div_ff, div_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [SUM_W-1:0] sum_mag;
   logic [CNT_W:0]   trial;
   logic [CNT_W:0]   trial_sub;
   logic             trial_ge;
   logic [EXT_W-1:0] mag_ext;
   logic [EXT_W-1:0] neg_ext;

   assign sum_mag   = start_sum[SUM_W-1] ? $unsigned(-start_sum) : $unsigned(start_sum);
   assign trial     = {rem_ff, dq_ff[Q_W-1]};
   assign trial_ge  = trial >= {1'b0, div_ff};
   assign trial_sub = trial - {1'b0, div_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in   = {sum_mag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         div_in  = start_count;
         cnt_in  = CW'(Q_W);
         neg_in  = start_sum[SUM_W-1];
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[Q_W-2:0], trial_ge};
         rem_in = trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   // sign and clamp of the finished quotient
   assign mag_ext = EXT_W'(dq_ff);
   assign neg_ext = ~mag_ext + EXT_W'(1);

   always_comb begin
      if (neg_ff) begin
         average = (mag_ext > NEG_LIM) ? AVG_MIN : $signed(neg_ext[AVG_BITS-1:0]);
      end else begin
         average = (mag_ext > POS_LIM) ? AVG_MAX : $signed(mag_ext[AVG_BITS-1:0]);
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

FILE: rtl/moving_average_window.sv
// Boxcar moving average: ring, running sum and bit-serial divider under one sequencer.
//
// Usage:
//  - req_ channel: one signed sample per transaction (req_valid / req_stall).
//  - rsp_ channel: one signed average per request, 8 fraction bits, truncated
//    toward zero (rsp_valid / rsp_stall). Results come out in request order.
//  - csr_ channel: writes window_length (valid / ready). Ready only while the
//    sequencer is idle; a write empties the window. 0 acts as 1, values above
//    MAX_WINDOW act as MAX_WINDOW.
//  - Sequence: an accepted request passes through the update, divide and
//    output states into the output register. The divider works on a
//    SUM_W-bit sum (SUM_W = SAMPLE_BITS + log2(MAX_WINDOW)) and retires one
//    quotient bit per cycle. Flow: a request is taken only while the
//    sequencer is idle, one sample at a time. A finished result waits in the
//    output register, so the next request is taken while it is stalled; a
//    second result waits for that register to drain.
//  - Reset: window empty, window_length = 8, no result pending.
//  - The ring value read back is used only at slots already written in this window.
`default_nettype none

`include "moving_average_window_defines.svh"

module moving_average_window #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [mavw_pkg::AVG_BITS-1:0] rsp_average,
   // window length register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mavw_pkg::WIN_BITS-1:0]        csr_window_length
);

   import mavw_pkg::*;

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int EW    = (WIN_BITS > CNT_W) ? WIN_BITS : CNT_W;

   state_type state_ff, state_in;

   logic [WIN_BITS-1:0]          win_ff, win_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic [CNT_W-1:0]             fill_ff, fill_in;
   logic [AW-1:0]                ptr_ff, ptr_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [AW-1:0]                slot_ff;
   logic                         full_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_BITS-1:0]   rsp_average_ff;

   logic                          csr_write;
   logic                          item_accept;
   logic                          do_update;
   logic                          load_rsp;
   logic [EW-1:0]                 win_ext;
   logic [CNT_W-1:0]              win_eff;
   logic                          is_full;
   logic [CNT_W-1:0]              ptr_plus;
   logic [CNT_W-1:0]              fill_next;
   logic signed [SAMPLE_BITS-1:0] ring_rd;
   logic signed [SUM_W-1:0]       old_term;
   logic signed [SUM_W-1:0]       sum_next;
   logic signed [AVG_BITS-1:0]    div_average;
   div_stat_type                  div_stat;

   // effective window, clamped to 1..MAX_WINDOW
   assign win_ext = EW'(win_ff);
   always_comb begin
      if (win_ff == '0) begin
         win_eff = CNT_W'(1);
      end else if (win_ext > EW'(MAX_WINDOW)) begin
         win_eff = CNT_W'(MAX_WINDOW);
      end else begin
         win_eff = CNT_W'(win_ext);
      end
   end

   assign is_full  = fill_ff >= win_eff;
   assign ptr_plus = CNT_W'(ptr_ff) + CNT_W'(1);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      csr_ready = 1'b0;
      do_update = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = csr_valid;   // a register write takes the cycle
            csr_ready = 1'b1;
         end
         ST_UPDATE: begin
            do_update = 1'b1;
         end
         ST_DIVIDE: begin
         end
         ST_OUTPUT: begin
            load_rsp = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   assign csr_write   = csr_valid && csr_ready;
   assign item_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------- window state
   // When full the oldest slot is read during the accept cycle and replaced
   // in the update cycle; while filling, the slot is the fill count.
   assign old_term  = full_ff ? SUM_W'(ring_rd) : '0;
   assign sum_next  = sum_ff + SUM_W'(sample_ff) - old_term;
   assign fill_next = full_ff ? fill_ff : fill_ff + CNT_W'(1);

   always_comb begin
      win_in  = win_ff;
      sum_in  = sum_ff;
      fill_in = fill_ff;
      ptr_in  = ptr_ff;
      if (csr_write) begin
         win_in  = csr_window_length;
         sum_in  = '0;
         fill_in = '0;
         ptr_in  = '0;
      end else if (do_update) begin
         sum_in  = sum_next;
         fill_in = fill_next;
         if (full_ff) begin
            ptr_in = (ptr_plus == win_eff) ? '0 : ptr_plus[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         win_ff   <= WIN_RESET;
         sum_ff   <= '0;
         fill_ff  <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         win_ff   <= win_in;
         sum_ff   <= sum_in;
         fill_ff  <= fill_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept) begin
         sample_ff <= req_sample;
         full_ff   <= is_full;
         slot_ff   <= is_full ? ptr_ff : fill_ff[AW-1:0];
      end
   end

   mavw_ring #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (SAMPLE_BITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (do_update),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (item_accept),
      .rd_addr (ptr_ff),
      .rd_data (ring_rd)
   );

   mavw_sdiv #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_sdiv (
      .clock       (clock),
      .reset       (reset),
      .start       (do_update),
      .start_sum   (sum_next),
      .start_count (fill_next),
      .stat        (div_stat),
      .average     (div_average)
   );

   // ---------------------------------------------------------------- output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_average_ff <= div_average;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

   // ---------------------------------------------------------------- checks
   `MAVW_ASSERT_IMPLY(a_fill_in_window, clock, reset, 1'b1, fill_ff <= win_eff)
   `MAVW_ASSERT_IMPLY(a_ptr_zero_filling, clock, reset, !is_full, ptr_ff == '0)
   `MAVW_ASSERT_NEXT(a_update_starts_div, clock, reset, state_ff == ST_UPDATE,
                     div_stat.busy && state_ff == ST_DIVIDE)
   `MAVW_ASSERT_IMPLY(a_div_done_in_divide, clock, reset, div_stat.done,
                      state_ff == ST_DIVIDE && !div_stat.busy)

endmodule

`default_nettype wire

FILE: bench/tb_moving_average_window.sv
// Self-checking testbench for the boxcar moving average window block.
module tb_moving_average_window;
   import mavw_pkg::*;

   localparam int MAX_WIN     = 64;
   localparam int SAMPLE_W    = 16;
   // Request-to-response delay at the defaults, for the 22-bit sum; sizes the final watch.
   localparam int LATENCY     = SAMPLE_W + 6 + FRAC_BITS + 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 50;

   // ---------------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic                       clock             = 1'b0;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample        = '0;
   logic                       rsp_valid;
   logic                       rsp_stall         = 1'b0;
   logic signed [AVG_BITS-1:0] rsp_average;
   logic                       csr_valid         = 1'b0;
   logic                       csr_ready;
   logic [WIN_BITS-1:0]        csr_window_length = '0;

   moving_average_window u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average       (rsp_average),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------------
   // Boxcar predictor: own copy of the ring, sum, fill count and head slot
   // ---------------------------------------------------------------------------
   logic [WIN_BITS-1:0]        win_len_reg;
   logic signed [SAMPLE_W-1:0] hist [MAX_WIN];
   longint                     win_sum;
   int                         win_count;
   int                         win_head;

   // Averages predicted for accepted samples, oldest first.
   logic signed [AVG_BITS-1:0] pending_averages [$];

   // Idle rates in percent per cycle, and the receiver hold-off counter.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left     = 0;

   int mismatches   = 0;
   int samples_in   = 0;
   int averages_out = 0;
   int csr_writes   = 0;
   int cycles       = 0;

   // Out-of-range lengths clamp: zero acts as one, above the ring depth acts as full depth.
   function automatic int effective_len(input logic [WIN_BITS-1:0] len);
      if (len == 0)
         return 1;
      if (len > MAX_WIN)
         return MAX_WIN;
      return int'(len);
   endfunction

   function automatic void clear_window();
      win_sum   = 0;
      win_count = 0;
      win_head  = 0;
   endfunction

   // Fold one sample into the window and return the fixed-point mean.
   function automatic logic signed [AVG_BITS-1:0] next_average(
      input logic signed [SAMPLE_W-1:0] s);
      int     w;
      int     slot;
      longint q;
      w = effective_len(win_len_reg);
      if (win_count < w) begin
         // still filling: divisor is the count so far
         hist[win_count % MAX_WIN] = s;
         win_sum += s;
         win_count++;
      end else begin
         // full: oldest sample leaves, new one takes its slot
         slot        = win_head % w;
         win_sum    -= hist[slot];
         hist[slot]  = s;
         win_sum    += s;
         win_head    = (slot + 1) % w;
      end
      // SV integer division truncates toward zero, as required
      q = (win_sum * (longint'(1) << FRAC_BITS)) / win_count;
      if (q > longint'(AVG_MAX))
         q = AVG_MAX;
      if (q < longint'(AVG_MIN))
         q = AVG_MIN;
      return AVG_BITS'(q);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("[%0t] ERROR: %s", $time, msg);
      else if (mismatches == PRINT_CAP + 1)
         $display("[%0t] further errors counted but not printed", $time);
   endtask

   // ---------------------------------------------------------------------------
   // Scoreboard: one process samples both channels at the rising edge.
   // The result side is checked first, so a response never pairs with the
   // request transaction taken on the same edge.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      logic signed [AVG_BITS-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         averages_out++;
         if (pending_averages.size() == 0) begin
            report_mismatch($sformatf("average %0d with no sample outstanding",
                                      rsp_average));
         end else begin
            want = pending_averages.pop_front();
            if (rsp_average !== want)
               report_mismatch($sformatf("average %0d, expected %0d (result %0d)",
                                         rsp_average, want, averages_out));
         end
      end
      if (!reset && req_valid && !req_stall) begin
         pending_averages.push_back(next_average(req_sample));
         samples_in++;
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stall per cycle, or a counted hold-off when requested.
   // The hold counter is loaded from the test tasks with a nonblocking write
   // only while it is zero, so this process is its only other writer.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Run limit; generous against the slowest legal run.
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles with %0d averages still due",
               cycles, pending_averages.size());
      $display("end of test: mismatches");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Transaction helpers. All of them are entered and left at a falling edge.
   // push_sample leaves valid high after its transaction; the caller either
   // pushes again at once or calls wait_idle, which drops it.
   // ---------------------------------------------------------------------------
   task automatic push_sample(input logic signed [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Every sample yields exactly one average, so an empty queue means idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_averages.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_window(input logic [WIN_BITS-1:0] len);
      wait_idle();
      csr_valid         <= 1'b1;
      csr_window_length <= len;
      do @(posedge clock); while (!csr_ready);
      // any write empties the window
      win_len_reg = len;
      clear_window();
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly full-range samples, with extremes and small values mixed in.
   function automatic logic signed [SAMPLE_W-1:0] rand_sample();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return SAMPLE_W'($urandom_range(64) - 32);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [WIN_BITS-1:0] pick_window();
      case ($urandom_range(7))
         0:       return 7'd1;
         1:       return 7'd64;
         2:       return 7'd0;
         3:       return 7'd127;
         4:       return WIN_BITS'($urandom_range(126, 65));
         default: return WIN_BITS'($urandom_range(63, 2));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset length of 8: fill, truncation of a negative mean, extremes, wrap.
   task automatic test_default_window();
      logic signed [SAMPLE_W-1:0] vals [9] = '{-16'sd1, 16'sd0, -16'sd1, 16'sh7FFF,
                                               16'sh7FFF, 16'sh8000, 16'sd1,
                                               16'sd12345, 16'sh7FFF};
      foreach (vals[i])
         push_sample(vals[i]);
   endtask

   // Shortest and longest windows, plus the clamped lengths.
   task automatic test_window_extremes();
      write_window(7'd1);
      push_sample(16'sh8000);
      push_sample(16'sh7FFF);
      push_sample(16'sd5);
      write_window(7'd0);       // acts as a window of one
      push_sample(16'sh7FFF);
      push_sample(16'sh8000);
      write_window(7'd127);     // all ones, acts as the full ring
      push_sample(16'sh8000);
      push_sample(16'sh8000);
      push_sample(16'sd3);
      write_window(7'd65);      // just past the ring depth
      push_sample(16'sd100);
      push_sample(-16'sd7);
   endtask

   // A write to the same length still restarts the average.
   task automatic test_rewrite_empties();
      write_window(7'd5);
      push_sample(16'sd1000);
      push_sample(-16'sd3);
      write_window(7'd5);
      push_sample(16'sd7);
      push_sample(-16'sd9);
   endtask

   // Segments of random samples, each under a freshly written length.
   // The first segment uses the full ring long enough to wrap it.
   task automatic test_random_phase(input int send_pct, input int recv_pct,
                                    input int count);
      int                  sent;
      int                  seg;
      logic [WIN_BITS-1:0] len;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent          = 0;
      len           = 7'd64;
      while (sent < count) begin
         write_window(len);
         seg = (sent == 0) ? 140 : $urandom_range(150, 20);
         for (int i = 0; i < seg && sent < count; i++) begin
            push_sample(rand_sample());
            sent++;
         end
         len = pick_window();
      end
   endtask

   // Receiver holds off while the sender keeps offering: the output register
   // and the divider fill and the block stalls its request side.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_window(7'd4);
      hold_left <= 300;
      repeat (10)
         push_sample(rand_sample());
      wait_idle();
   endtask

   initial begin
      win_len_reg = WIN_RESET;
      clear_window();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_window();
      test_window_extremes();
      test_rewrite_empties();
      test_random_phase(34, 83, 400);
      test_random_phase(83, 34, 400);
      test_random_phase(0, 0, 400);
      test_backpressure();

      // Drain, then watch a while longer for stray responses.
      wait_idle();
      repeat (2 * LATENCY) @(negedge clock);
      if (pending_averages.size() != 0)
         report_mismatch($sformatf("%0d averages never arrived", pending_averages.size()));

      $display("covered %0d samples and %0d averages over %0d window writes,",
               samples_in, averages_out, csr_writes);
      $display("with clamped lengths, restarts, idle mixes and a long receiver hold-off");
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/mavw_pkg.sv
rtl/mavw_ring.sv
rtl/mavw_sdiv.sv
rtl/moving_average_window.sv
bench/tb_moving_average_window.sv
